FILE: rtl/gol_pkg.sv
// ----------------------------------------------------------------------------
// gol_pkg: shared types and constants for the toroidal B3/S23 life engine
// Grid geometry, request codes, register indexes, state encoding and the
// control and read-data bundles between the sequencer and the grid store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gol_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam int COL_W  = 6;
   localparam int ROW_W  = 6;
   localparam int SIZE_W = 7;
   localparam int CSR_IDX_W = 1;

   localparam int SURVIVE_COUNT = 2;
   localparam int BIRTH_COUNT   = 3;

   // step pass: two lead reads, one more before the first row is complete
   localparam int STEP_LEAD = 3;
   localparam int STEP_LAST = MAX_HEIGHT + STEP_LEAD - 1;
   localparam int CNT_W     = $clog2(STEP_LAST + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_IDX  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_IDX = 1'b1;

   typedef logic [MAX_WIDTH-1:0] row_type;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_STEP  = 2'd2
   } req_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_STEP,
      ST_CMP,
      ST_DONE
   } gol_state_type;

   typedef struct packed {
      logic             live_we;
      logic [ROW_W-1:0] live_wa;
      row_type          live_wd;
      logic [ROW_W-1:0] live_ra;
      logic             hist_we;
      logic [ROW_W-1:0] hist_wa;
      row_type          last_wd;
      row_type          older_wd;
      logic [ROW_W-1:0] hist_ra;
   } store_ctrl_type;

   typedef struct packed {
      row_type live;
      row_type last;
      row_type older;
   } store_rd_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] top);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = SIZE_W'(1);
      else if (v > top) r = top;
      return r;
   endfunction

   function automatic row_type col_mask(input logic [SIZE_W-1:0] w);
      row_type m;
      for (int x = 0; x < MAX_WIDTH; x++) m[x] = (SIZE_W'(x) < w);
      return m;
   endfunction

endpackage

FILE: rtl/gol_if.sv
// ----------------------------------------------------------------------------
// gol_if: request and response channels of the life engine
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gol_req_if import gol_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic             cell_in;

   modport source (output valid, output req_type, output col, output row,
                   output cell_in, input ready);
   modport sink   (input valid, input req_type, input col, input row,
                   input cell_in, output ready);
endinterface

interface gol_rsp_if import gol_pkg::*; ();
   logic valid;
   logic ready;
   logic cell_out;
   logic still_life;
   logic period_two;
   logic coord_error;

   modport source (output valid, output cell_out, output still_life,
                   output period_two, output coord_error, input ready);
   modport sink   (input valid, input cell_out, input still_life,
                   input period_two, input coord_error, output ready);
endinterface

FILE: rtl/gol_row_unit.sv
// ----------------------------------------------------------------------------
// gol_row_unit: next-generation logic for one grid row
// Counts the eight wrapped neighbors of every active column and applies
// B3/S23; columns past the active width keep their value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gol_row_unit import gol_pkg::*; (
   input  row_type           up_row,
   input  row_type           mid_row,
   input  row_type           down_row,
   input  logic [SIZE_W-1:0] width,
   output row_type           next_row
);

   logic [COL_W-1:0] wm1;
   logic [COL_W-1:0] lx [MAX_WIDTH];
   logic [COL_W-1:0] rx [MAX_WIDTH];
   logic [3:0]       nsum [MAX_WIDTH];

   assign wm1 = COL_W'(width - SIZE_W'(1));

   always_comb begin
      for (int x = 0; x < MAX_WIDTH; x++) begin
         lx[x] = (x == 0) ? wm1 : COL_W'(x - 1);
         rx[x] = (COL_W'(x) == wm1) ? '0 : COL_W'(x + 1);
      end
   end

   always_comb begin
      for (int x = 0; x < MAX_WIDTH; x++) begin
         nsum[x] = 4'(up_row[lx[x]])   + 4'(up_row[x])   + 4'(up_row[rx[x]])
                 + 4'(mid_row[lx[x]])                     + 4'(mid_row[rx[x]])
                 + 4'(down_row[lx[x]]) + 4'(down_row[x]) + 4'(down_row[rx[x]]);
         if (SIZE_W'(x) >= width) begin
            next_row[x] = mid_row[x];
         end else if (mid_row[x]) begin
            next_row[x] = (nsum[x] == 4'(SURVIVE_COUNT)) || (nsum[x] == 4'(BIRTH_COUNT));
         end else begin
            next_row[x] = (nsum[x] == 4'(BIRTH_COUNT));
         end
      end
   end

endmodule

FILE: rtl/gol_grid_store.sv
// ----------------------------------------------------------------------------
// gol_grid_store: live, last and older generation memories
// One write and one registered read per memory each cycle; last and older
// share addresses. Rows never written read as dead through per-row valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gol_grid_store import gol_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  store_ctrl_type ctrl,
   output store_rd_type   rd
);

   row_type                 live_mem_ff  [MAX_HEIGHT];
   row_type                 last_mem_ff  [MAX_HEIGHT];
   row_type                 older_mem_ff [MAX_HEIGHT];
   logic [MAX_HEIGHT-1:0]   live_vld_ff;
   logic [MAX_HEIGHT-1:0]   hist_vld_ff;
   store_rd_type            rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_vld_ff <= '0;
         hist_vld_ff <= '0;
      end else begin
         if (ctrl.live_we) live_vld_ff[ctrl.live_wa] <= 1'b1;
         if (ctrl.hist_we) hist_vld_ff[ctrl.hist_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.live_we) live_mem_ff[ctrl.live_wa] <= ctrl.live_wd;
      if (ctrl.hist_we) begin
         last_mem_ff[ctrl.hist_wa]  <= ctrl.last_wd;
         older_mem_ff[ctrl.hist_wa] <= ctrl.older_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff.live  <= live_vld_ff[ctrl.live_ra] ? live_mem_ff[ctrl.live_ra] : '0;
      rd_ff.last  <= hist_vld_ff[ctrl.hist_ra] ? last_mem_ff[ctrl.hist_ra] : '0;
      rd_ff.older <= hist_vld_ff[ctrl.hist_ra] ? older_mem_ff[ctrl.hist_ra] : '0;
   end

   assign rd = rd_ff;

endmodule

FILE: rtl/life_cellular_automaton_torus_top.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_torus_top: toroidal B3/S23 life engine
// Cell write/read in range: an access state, then a compare sweep over the
// active rows; out-of-range access or unused code: the compare sweep only.
// Generation step: one row per cycle, all 64 rows swept, with the stability
// flags gathered during the sweep.
// A waiting result stalls only the next result. Reset clears row valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_cellular_automaton_torus_top import gol_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   gol_req_if.sink              req_chan,
   gol_rsp_if.source            rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data
);

   gol_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [SIZE_W-1:0] eff_w, eff_h;

   logic [1:0]        op_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              cell_ff;
   logic              coord_err_ff;
   logic              cell_out_ff;
   logic              still_ff;
   logic              period_ff;
   row_type           up_ff, mid_ff, row0_ff;

   logic              rsp_valid_ff;
   logic              rsp_cell_ff, rsp_still_ff, rsp_period_ff, rsp_err_ff;

   store_ctrl_type    ctrl;
   store_rd_type      rd;
   row_type           mask;
   row_type           below_row, next_row, wr_row;
   logic [ROW_W-1:0]  step_row;
   logic              step_active, below_wrap;
   logic              accept, in_range, is_access, rsp_load;

   assign eff_w = clamp_size(width_ff, SIZE_W'(MAX_WIDTH));
   assign eff_h = clamp_size(height_ff, SIZE_W'(MAX_HEIGHT));
   assign mask  = col_mask(eff_w);

   assign accept    = req_chan.valid && req_chan.ready;
   assign is_access = req_chan.req_type inside {REQ_WRITE, REQ_READ};
   assign in_range  = (SIZE_W'(req_chan.col) < eff_w) && (SIZE_W'(req_chan.row) < eff_h);

   assign step_row    = ROW_W'(cnt_ff - CNT_W'(STEP_LEAD));
   assign step_active = SIZE_W'(step_row) < eff_h;
   assign below_wrap  = SIZE_W'(step_row) == (eff_h - SIZE_W'(1));
   assign below_row   = below_wrap ? row0_ff : rd.live;

   always_comb begin
      wr_row         = rd.live;
      wr_row[col_ff] = cell_ff;
   end

   gol_row_unit u_row (
      .up_row   (up_ff),
      .mid_row  (mid_ff),
      .down_row (below_row),
      .width    (eff_w),
      .next_row (next_row)
   );

   gol_grid_store u_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .rd    (rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               case (req_chan.req_type)
                  REQ_STEP:            state_in = ST_STEP;
                  REQ_WRITE, REQ_READ: state_in = in_range ? ST_ACCESS : ST_CMP;
                  default:             state_in = ST_CMP;
               endcase
            end
         end
         ST_ACCESS: begin
            state_in = ST_CMP;
            cnt_in   = '0;
         end
         ST_CMP: begin
            if (cnt_ff == CNT_W'(eff_h)) state_in = ST_DONE;
            else cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_STEP: begin
            if (cnt_ff == CNT_W'(STEP_LAST)) state_in = ST_DONE;
            else cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl           = '0;
      req_chan.ready = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            ctrl.live_ra   = req_chan.row;
         end
         ST_ACCESS: begin
            ctrl.live_we = (op_ff == REQ_WRITE);
            ctrl.live_wa = row_ff;
            ctrl.live_wd = wr_row;
         end
         ST_CMP: begin
            ctrl.live_ra = ROW_W'(cnt_ff);
            ctrl.hist_ra = ROW_W'(cnt_ff);
         end
         ST_STEP: begin
            ctrl.live_ra = (cnt_ff == '0) ? ROW_W'(eff_h - SIZE_W'(1))
                                          : ROW_W'(cnt_ff - CNT_W'(1));
            ctrl.hist_ra = ROW_W'(cnt_ff - CNT_W'(2));
            if (cnt_ff >= CNT_W'(STEP_LEAD)) begin
               ctrl.live_we  = 1'b1;
               ctrl.live_wa  = step_row;
               ctrl.live_wd  = step_active ? next_row : mid_ff;
               ctrl.hist_we  = 1'b1;
               ctrl.hist_wa  = step_row;
               ctrl.last_wd  = mid_ff;
               ctrl.older_wd = rd.last;
            end
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= SIZE_W'(MAX_WIDTH);
         height_ff    <= SIZE_W'(MAX_HEIGHT);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         if (csr_write_en) begin
            case (csr_index)
               CSR_WIDTH_IDX:  width_ff  <= csr_data;
               CSR_HEIGHT_IDX: height_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_ff        <= req_chan.req_type;
               col_ff       <= req_chan.col;
               row_ff       <= req_chan.row;
               cell_ff      <= req_chan.cell_in;
               coord_err_ff <= is_access && !in_range;
               cell_out_ff  <= 1'b0;
               still_ff     <= 1'b1;
               period_ff    <= 1'b1;
            end
         end
         ST_ACCESS: begin
            if (op_ff == REQ_READ) cell_out_ff <= rd.live[col_ff];
         end
         ST_CMP: begin
            if (cnt_ff != '0) begin
               still_ff  <= still_ff  && (((rd.live ^ rd.last)  & mask) == '0);
               period_ff <= period_ff && (((rd.live ^ rd.older) & mask) == '0);
            end
         end
         ST_STEP: begin
            if (cnt_ff == CNT_W'(1)) up_ff <= rd.live;
            if (cnt_ff == CNT_W'(2)) begin
               mid_ff  <= rd.live;
               row0_ff <= rd.live;
            end
            if (cnt_ff >= CNT_W'(STEP_LEAD)) begin
               if (step_active) begin
                  still_ff  <= still_ff  && (((next_row ^ mid_ff)  & mask) == '0);
                  period_ff <= period_ff && (((next_row ^ rd.last) & mask) == '0);
               end
               up_ff  <= mid_ff;
               mid_ff <= rd.live;
            end
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_cell_ff   <= cell_out_ff;
         rsp_still_ff  <= still_ff;
         rsp_period_ff <= period_ff;
         rsp_err_ff    <= coord_err_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cell_out    = rsp_cell_ff;
   assign rsp_chan.still_life  = rsp_still_ff;
   assign rsp_chan.period_two  = rsp_period_ff;
   assign rsp_chan.coord_error = rsp_err_ff;

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start work");

   a_cmp_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (cnt_ff <= CNT_W'(eff_h)))
      else $error("compare sweep ran past active height");

   a_step_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && op_ff == REQ_STEP) |-> (!coord_err_ff && !cell_out_ff))
      else $error("generation step reported cell or coordinate error");

   a_err_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.coord_error && rsp_chan.cell_out))
      else $error("rejected access returned a cell value");
`endif

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the toroidal B3/S23 life engine
// Cell writes, cell reads and generation steps go in over a valid/ready
// channel, with random gaps on the request side and random stalls on the
// result side. A local copy of the three grids and the size registers
// predicts every result beat, which is checked field by field in order.
// Grid sizes change between phases only, once all results are in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import gol_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             cell_in;
   } cell_req_t;

   typedef struct packed {
      logic cell_out;
      logic still_life;
      logic period_two;
      logic coord_error;
   } cell_rsp_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_data;

   gol_req_if req_chan ();
   gol_rsp_if rsp_chan ();

   life_cellular_automaton_torus_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // local copy of the block state
   row_type           live_g  [MAX_HEIGHT];
   row_type           last_g  [MAX_HEIGHT];
   row_type           older_g [MAX_HEIGHT];
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;

   cell_req_t req_backlog [$];
   cell_rsp_t flags_due [$];

   int  send_gap;
   int  hold_cnt;
   bit  steady;
   int  mismatches;
   int  items_queued;
   int  beats_checked;
   int  size_settings;
   int  steps_seen;
   int  reads_seen;
   int  range_errors;
   int  still_hits;
   int  period_hits;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(30_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int span_of(input logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return int'(v);
   endfunction

   function automatic logic area_equal(input row_type a [MAX_HEIGHT],
                                       input row_type b [MAX_HEIGHT],
                                       input int w, input int h);
      row_type m;
      m = (w >= MAX_WIDTH) ? '1 : ((row_type'(1) << w) - 1);
      for (int y = 0; y < h; y++)
         if (((a[y] ^ b[y]) & m) != '0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void life_generation(input int w, input int h);
      row_type nxt [MAX_HEIGHT];
      int n;
      int yy;
      int xx;
      nxt = live_g;
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dx = -1; dx <= 1; dx++) begin
                  if (dy != 0 || dx != 0) begin
                     yy = (y + dy + h) % h;
                     xx = (x + dx + w) % w;
                     n += int'(live_g[yy][xx]);
                  end
               end
            end
            if (live_g[y][x])
               nxt[y][x] = (n == SURVIVE_COUNT || n == BIRTH_COUNT);
            else
               nxt[y][x] = (n == BIRTH_COUNT);
         end
      end
      older_g = last_g;
      last_g  = live_g;
      live_g  = nxt;
   endfunction

   function automatic cell_rsp_t life_apply(input cell_req_t rq);
      cell_rsp_t res;
      int w;
      int h;
      w = span_of(width_reg);
      h = span_of(height_reg);
      res = '0;
      if (rq.kind == REQ_WRITE || rq.kind == REQ_READ) begin
         if (int'(rq.col) >= w || int'(rq.row) >= h) begin
            res.coord_error = 1'b1;
            range_errors++;
         end else if (rq.kind == REQ_WRITE) begin
            live_g[rq.row][rq.col] = rq.cell_in;
         end else begin
            res.cell_out = live_g[rq.row][rq.col];
            reads_seen++;
         end
      end else if (rq.kind == REQ_STEP) begin
         life_generation(w, h);
         steps_seen++;
      end
      res.still_life = area_equal(live_g, last_g, w, h);
      res.period_two = area_equal(live_g, older_g, w, h);
      still_hits  += res.still_life;
      period_hits += res.period_two;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void check_field(input string what, input logic want, input logic got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t ns: %s mismatch, expected %0b actual %0b", $time, what, want, got);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      cell_req_t nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            nxt.kind    = req_chan.req_type;
            nxt.col     = req_chan.col;
            nxt.row     = req_chan.row;
            nxt.cell_in = req_chan.cell_in;
            flags_due.push_back(life_apply(nxt));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               req_chan.valid <= 1'b0;
               send_gap--;
            end else if (req_backlog.size() > 0) begin
               nxt = req_backlog.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.req_type <= nxt.kind;
               req_chan.col      <= nxt.col;
               req_chan.row      <= nxt.row;
               req_chan.cell_in  <= nxt.cell_in;
               send_gap = pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      cell_rsp_t want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (flags_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 40)
                  $display("%0t ns: result beat with nothing expected", $time);
            end else begin
               want = flags_due.pop_front();
               beats_checked++;
               check_field("cell_out", want.cell_out, rsp_chan.cell_out);
               check_field("still_life", want.still_life, rsp_chan.still_life);
               check_field("period_two", want.period_two, rsp_chan.period_two);
               check_field("coord_error", want.coord_error, rsp_chan.coord_error);
            end
         end
         if (hold_cnt > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_cnt--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(99) < 15) hold_cnt = pick_gap();
         end
      end
   end

   function automatic void add_req(input logic [1:0] kind, input int col, input int row,
                                   input int v);
      cell_req_t rq;
      rq.kind    = kind;
      rq.col     = COL_W'(col);
      rq.row     = ROW_W'(row);
      rq.cell_in = v[0];
      req_backlog.push_back(rq);
      items_queued++;
   endfunction

   function automatic void add_noise(input int w, input int h);
      case ($urandom_range(3))
         0: add_req(REQ_UNUSED, $urandom, $urandom, $urandom);
         1: begin
            if (w < MAX_WIDTH)
               add_req($urandom_range(1) ? REQ_READ : REQ_WRITE, $urandom_range(w, 63),
                       $urandom_range(63), $urandom_range(1));
            else
               add_req(REQ_READ, $urandom, $urandom, $urandom);
         end
         2: begin
            if (h < MAX_HEIGHT)
               add_req($urandom_range(1) ? REQ_READ : REQ_WRITE, $urandom_range(63),
                       $urandom_range(h, 63), $urandom_range(1));
            else
               add_req(REQ_WRITE, $urandom, $urandom, $urandom);
         end
         default: add_req($urandom_range(1) ? REQ_READ : REQ_WRITE, $urandom, $urandom,
                          $urandom);
      endcase
   endfunction

   function automatic void seed_shape(input int w, input int h);
      int px [5];
      int py [5];
      int pn;
      int ox;
      int oy;
      case ($urandom_range(2))
         0: begin
            px = '{0, 1, 0, 1, 0};
            py = '{0, 0, 1, 1, 0};
            pn = 4;
         end
         1: begin
            px = '{0, 1, 2, 0, 0};
            py = '{0, 0, 0, 0, 0};
            pn = 3;
         end
         default: begin
            px = '{1, 2, 0, 1, 2};
            py = '{0, 1, 2, 2, 2};
            pn = 5;
         end
      endcase
      ox = $urandom_range(w - 1);
      oy = $urandom_range(h - 1);
      for (int i = 0; i < pn; i++)
         add_req(REQ_WRITE, (ox + px[i]) % w, (oy + py[i]) % h, 1);
   endfunction

   function automatic int pick_size();
      int edges [6];
      int r;
      edges = '{0, 1, 2, 64, 65, 127};
      r = $urandom_range(99);
      if (r < 12) return edges[$urandom_range(5)];
      if (r < 25) return $urandom_range(127);
      if (r < 33) return MAX_WIDTH;
      return $urandom_range(1, 10);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int v);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= SIZE_W'(v);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_size(input int wv, input int hv);
      write_reg(CSR_WIDTH_IDX, wv);
      write_reg(CSR_HEIGHT_IDX, hv);
      width_reg  = SIZE_W'(wv);
      height_reg = SIZE_W'(hv);
      size_settings++;
   endtask

   task automatic drain();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_chan.valid || flags_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic random_phase();
      int w;
      int h;
      int n;
      set_size(pick_size(), pick_size());
      steady = ($urandom_range(7) == 0);
      w = span_of(width_reg);
      h = span_of(height_reg);
      n = $urandom_range(2, 12);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0, 1, 2: seed_shape(w, h);
            9: add_noise(w, h);
            default: add_req(REQ_WRITE, $urandom_range(w - 1), $urandom_range(h - 1),
                             $urandom_range(99) < 75);
         endcase
      end
      n = $urandom_range(3, 10);
      for (int k = 0; k < n; k++) begin
         add_req(REQ_STEP, $urandom, $urandom, $urandom);
         repeat ($urandom_range(3))
            add_req(REQ_READ, $urandom_range(w - 1), $urandom_range(h - 1), $urandom);
         if ($urandom_range(9) == 0) add_noise(w, h);
         if ($urandom_range(9) == 0)
            add_req(REQ_WRITE, $urandom_range(w - 1), $urandom_range(h - 1), $urandom);
      end
   endtask

   initial begin
      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_index         = CSR_WIDTH_IDX;
      csr_data          = '0;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_WRITE;
      req_chan.col      = '0;
      req_chan.row      = '0;
      req_chan.cell_in  = 1'b0;
      rsp_chan.ready    = 1'b0;
      for (int y = 0; y < MAX_HEIGHT; y++) begin
         live_g[y]  = '0;
         last_g[y]  = '0;
         older_g[y] = '0;
      end
      width_reg  = SIZE_W'(MAX_WIDTH);
      height_reg = SIZE_W'(MAX_HEIGHT);
      steady     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // full grid: corners wrap onto each other, unused request code
      add_req(REQ_READ, 0, 0, 0);
      add_req(REQ_WRITE, 63, 63, 1);
      add_req(REQ_READ, 63, 63, 0);
      add_req(REQ_WRITE, 0, 0, 1);
      add_req(REQ_STEP, 0, 0, 0);
      add_req(REQ_UNUSED, 63, 63, 1);
      add_req(REQ_STEP, 63, 63, 1);
      add_req(REQ_WRITE, 63, 63, 0);
      drain();

      // zero width saturates to one column, oversized height to full
      set_size(0, 127);
      add_req(REQ_WRITE, 1, 0, 1);
      add_req(REQ_WRITE, 0, 3, 1);
      add_req(REQ_STEP, 0, 0, 0);
      add_req(REQ_READ, 0, 3, 0);
      add_req(REQ_READ, 0, 63, 0);
      drain();

      // single cell is its own eight neighbours
      set_size(1, 1);
      add_req(REQ_WRITE, 0, 0, 1);
      add_req(REQ_STEP, 0, 0, 0);
      add_req(REQ_READ, 0, 0, 0);
      add_req(REQ_READ, 0, 1, 0);
      drain();

      // two rows tall: neighbours above and below are the same row
      set_size(127, 2);
      add_req(REQ_WRITE, 10, 1, 1);
      add_req(REQ_WRITE, 11, 1, 1);
      add_req(REQ_WRITE, 12, 1, 1);
      add_req(REQ_STEP, 0, 0, 0);
      add_req(REQ_STEP, 0, 0, 0);
      add_req(REQ_READ, 11, 0, 0);
      drain();

      while (items_queued < 2000) begin
         random_phase();
         drain();
      end

      // hold for any stray beat
      repeat (80) @(posedge clock);

      $display("Checked %0d result beats over %0d size settings: %0d generation steps, %0d reads, %0d out-of-range accesses.",
               beats_checked, size_settings, steps_seen, reads_seen, range_errors);
      $display("Stability flags raised: still life %0d times, period two %0d times.",
               still_hits, period_hits);
      if (mismatches == 0 && flags_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/gol_pkg.sv
rtl/gol_if.sv
rtl/gol_row_unit.sv
rtl/gol_grid_store.sv
rtl/life_cellular_automaton_torus_top.sv
verif/tb.sv
